[rtl/sphd_pkg.sv]
// Shared types, register indexes and the decay factor table of the speech peak trigger.
`timescale 1ns / 1ps
`default_nettype none

package sphd_pkg;

	localparam int PROB_W   = 16;
	localparam int HOLD_W   = 9;
	localparam int LIMIT_W  = 8;
	localparam int FACTOR_W = 17;
	localparam int KIDX_W   = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 8'd1;

	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RESET        = 8'd5;
	localparam logic [PROB_W-1:0]  TRIGGER_THRESHOLD_RESET = 16'd45875;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_TRANSCRIBE = 2'd1,
		ACT_FLUSH      = 2'd2
	} action_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] hold_limit;
		logic [PROB_W-1:0]  trigger_threshold;
	} cfg_t;

	// round(65536 * exp(-0.25 * k)); zero from k = 48 on.
	function automatic logic [FACTOR_W-1:0] decay_factor(input logic [KIDX_W-1:0] k);
		logic [FACTOR_W-1:0] f;
		case (k)
			8'd0:  f = 17'd65536;
			8'd1:  f = 17'd51039;
			8'd2:  f = 17'd39750;
			8'd3:  f = 17'd30957;
			8'd4:  f = 17'd24109;
			8'd5:  f = 17'd18776;
			8'd6:  f = 17'd14623;
			8'd7:  f = 17'd11388;
			8'd8:  f = 17'd8869;
			8'd9:  f = 17'd6907;
			8'd10: f = 17'd5380;
			8'd11: f = 17'd4190;
			8'd12: f = 17'd3263;
			8'd13: f = 17'd2541;
			8'd14: f = 17'd1979;
			8'd15: f = 17'd1541;
			8'd16: f = 17'd1200;
			8'd17: f = 17'd935;
			8'd18: f = 17'd728;
			8'd19: f = 17'd567;
			8'd20: f = 17'd442;
			8'd21: f = 17'd344;
			8'd22: f = 17'd268;
			8'd23: f = 17'd209;
			8'd24: f = 17'd162;
			8'd25: f = 17'd127;
			8'd26: f = 17'd99;
			8'd27: f = 17'd77;
			8'd28: f = 17'd60;
			8'd29: f = 17'd47;
			8'd30: f = 17'd36;
			8'd31: f = 17'd28;
			8'd32: f = 17'd22;
			8'd33: f = 17'd17;
			8'd34: f = 17'd13;
			8'd35: f = 17'd10;
			8'd36: f = 17'd8;
			8'd37: f = 17'd6;
			8'd38: f = 17'd5;
			8'd39: f = 17'd4;
			8'd40: f = 17'd3;
			8'd41: f = 17'd2;
			8'd42: f = 17'd2;
			8'd43: f = 17'd1;
			8'd44: f = 17'd1;
			8'd45: f = 17'd1;
			8'd46: f = 17'd1;
			8'd47: f = 17'd1;
			default: f = 17'd0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

[rtl/sphd_core.sv]
// Peak, hold, decay and trigger state with the per-frame update logic.
`timescale 1ns / 1ps
`default_nettype none

module sphd_core #(
	parameter int DECAY_STEPS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [sphd_pkg::PROB_W-1:0]  prob,
	input  wire sphd_pkg::cfg_t               cfg,
	output sphd_pkg::action_t                 action,
	output logic [sphd_pkg::PROB_W-1:0]       reported_peak
);

	localparam int DC_W = $clog2(DECAY_STEPS);
	localparam logic [DC_W-1:0] DC_MAX = DC_W'(DECAY_STEPS - 1);

	logic [sphd_pkg::PROB_W-1:0] peak_q;
	logic [sphd_pkg::HOLD_W-1:0] hold_q;
	logic [DC_W-1:0]             decay_q;
	logic                        trig_q;

	logic [sphd_pkg::PROB_W-1:0] peak_next;
	logic [sphd_pkg::HOLD_W-1:0] hold_next;
	logic [DC_W-1:0]             decay_next;
	logic                        trig_next;
	logic [sphd_pkg::PROB_W-1:0] upd_peak;
	logic [sphd_pkg::FACTOR_W-1:0] factor;
	logic [32:0]                 prod;
	logic [32:0]                 rounded;

	assign factor  = sphd_pkg::decay_factor(sphd_pkg::KIDX_W'(decay_q));
	assign prod    = 33'(peak_q) * 33'(factor);
	assign rounded = prod + 33'd32768;

	always_comb begin
		upd_peak   = peak_q;
		hold_next  = hold_q;
		decay_next = decay_q;
		if (prob > peak_q) begin
			upd_peak   = prob;
			decay_next = '0;
		end else if (hold_q <= {1'b0, cfg.hold_limit}) begin
			hold_next = hold_q + 9'd1;
		end else begin
			hold_next = '0;
			upd_peak  = rounded[31:16];
			if (decay_q < DC_MAX) begin
				decay_next = decay_q + DC_W'(1);
			end
		end

		peak_next = upd_peak;
		trig_next = trig_q;
		action    = sphd_pkg::ACT_NONE;
		if (upd_peak >= cfg.trigger_threshold) begin
			action    = sphd_pkg::ACT_TRANSCRIBE;
			trig_next = 1'b1;
		end else if (trig_q) begin
			action    = sphd_pkg::ACT_FLUSH;
			trig_next = 1'b0;
			peak_next = '0;
		end
	end

	assign reported_peak = upd_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			hold_q  <= '0;
			decay_q <= '0;
			trig_q  <= 1'b0;
		end else if (step) begin
			peak_q  <= peak_next;
			hold_q  <= hold_next;
			decay_q <= decay_next;
			trig_q  <= trig_next;
		end
	end

endmodule

`default_nettype wire

[rtl/speech_peak_hold_decay_trigger.sv]
// Top level of the speech peak-hold-decay trigger: stream ports, config registers, pipeline.
`timescale 1ns / 1ps
`default_nettype none
// An accepted input item goes through the input register and then the result register.
// Throughput: one item per cycle unless m_tready stalls the output; the whole frame update
// (one 16x17 multiply, a round, and the threshold compare) fits between the two registers.
// Reset (arst_n low, asynchronous) clears the peak, hold, decay and trigger state,
// empties both pipeline registers and loads hold_limit 5 and trigger_threshold 45875.

module speech_peak_hold_decay_trigger #(
	parameter int DECAY_STEPS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [sphd_pkg::PROB_W-1:0]      s_tdata,   // [15:0] speech_probability
	// Result stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [sphd_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [1:0] action, [17:2] reported_peak
	// Configuration write port.
	input  wire logic                             cfg_we,
	input  wire logic [sphd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sphd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// Configuration registers. Writes to unknown indexes are dropped.
	sphd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_limit        <= sphd_pkg::HOLD_LIMIT_RESET;
			cfg_q.trigger_threshold <= sphd_pkg::TRIGGER_THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sphd_pkg::REG_HOLD_LIMIT:
					cfg_q.hold_limit <= cfg_wdata[sphd_pkg::LIMIT_W-1:0];
				sphd_pkg::REG_TRIGGER_THRESHOLD:
					cfg_q.trigger_threshold <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register. An item moves on into the result register whenever that
	// register is empty or is being emptied this cycle, and the frame state is
	// updated at that same edge, so back-to-back items see each other's state.
	logic                        valid_s1;
	logic [sphd_pkg::PROB_W-1:0] prob_s1;
	logic                        advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			prob_s1 <= s_tdata;
		end
	end

	// Frame update.
	sphd_pkg::action_t           act_c;
	logic [sphd_pkg::PROB_W-1:0] peak_c;

	sphd_core #(
		.DECAY_STEPS (DECAY_STEPS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.prob          (prob_s1),
		.cfg           (cfg_q),
		.action        (act_c),
		.reported_peak (peak_c)
	);

	// Result register.
	logic                        out_valid_q;
	sphd_pkg::action_t           out_act_q;
	logic [sphd_pkg::PROB_W-1:0] out_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_act_q  <= act_c;
			out_peak_q <= peak_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_peak_q, out_act_q};

	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the result register was empty");

	// A waiting item with room downstream shows up as a result next cycle.
	a_item_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("item in the input register did not reach the output");

	// The input register only empties by moving its item into the result register.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s_tready |=> valid_s1)
		else $error("input item lost while stalled");

endmodule

`default_nettype wire

[verif/tb_speech_peak_hold_decay_trigger.sv]
// Self-checking testbench for the speech peak-hold-decay trigger.
`timescale 1ns / 1ps

module tb_speech_peak_hold_decay_trigger;

	localparam int SETTLE_CYCLES = 4;      // pipeline is two deep; a little margin
	localparam int STALL_LIMIT   = 5000;   // cycles with no item moving on either side
	localparam int HOLD_OFF_LEN  = 300;    // long receiver hold-off in the pressure test
	localparam logic [5:0] DECAY_LAST = 6'd63;
	localparam int FACTOR_COUNT  = 48;

	// Writes to these indexes must leave both registers untouched.
	localparam logic [sphd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd2;
	localparam logic [sphd_pkg::CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

	// Decay factors round(65536 * exp(-0.25 * k)); zero from k = 48 on.
	localparam int unsigned EXP_QUARTER_STEP [0:FACTOR_COUNT-1] = '{
		65536, 51039, 39750, 30957, 24109, 18776, 14623, 11388,
		8869, 6907, 5380, 4190, 3263, 2541, 1979, 1541,
		1200, 935, 728, 567, 442, 344, 268, 209,
		162, 127, 99, 77, 60, 47, 36, 28,
		22, 17, 13, 10, 8, 6, 5, 4,
		3, 2, 2, 1, 1, 1, 1, 1
	};

	typedef struct packed {
		sphd_pkg::action_t act;
		logic [15:0]       peak;
	} frame_result_t;

	// Receiver behaviors; the pattern mode follows a rotating mask of its own.
	typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                                   clk       = 1'b0;
	logic                                   arst_n    = 1'b0;
	logic                                   s_tvalid  = 1'b0;
	logic                                   s_tready;
	logic [sphd_pkg::PROB_W-1:0]            s_tdata   = '0;  // [15:0] speech_probability
	logic                                   m_tvalid;
	logic                                   m_tready  = 1'b0;
	logic [sphd_pkg::OUT_TDATA_W-1:0]       m_tdata;  // [1:0] action, [17:2] reported_peak
	logic                                   cfg_we    = 1'b0;
	logic [sphd_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [sphd_pkg::CFG_DATA_W-1:0]        cfg_wdata = '0;

	// Our own copy of the trigger state and its registers.
	logic [15:0] pk_level;
	logic [8:0]  hold_cnt;
	logic [5:0]  decay_idx;
	logic        armed;
	logic [7:0]  cfg_hold_limit;
	logic [15:0] cfg_threshold;

	frame_result_t expected_frames[$];

	rx_mode_t   rx_mode = RX_ALWAYS;
	logic [6:0] rx_pattern = 7'b1011001;
	int         hold_off_request = 0;
	int         hold_left = 0;
	bit         sender_idles = 1'b0;
	int         burst_left = 0;

	int errors = 0;
	int frames_sent = 0;
	int frames_checked = 0;
	int transcribes_seen = 0;
	int flushes_seen = 0;
	int reg_writes = 0;
	int idle_cycles = 0;

	speech_peak_hold_decay_trigger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// One frame of the peak tracker: rise, hold or decay, then the threshold decision.
	// The reported peak is taken before a flush clears it.
	function automatic frame_result_t advance_frame(input logic [15:0] prob);
		frame_result_t r;
		logic [16:0]   f;
		logic [33:0]   scaled;
		if (prob > pk_level) begin
			pk_level  = prob;
			decay_idx = '0;
		end else if (hold_cnt <= {1'b0, cfg_hold_limit}) begin
			hold_cnt = hold_cnt + 9'd1;
		end else begin
			f = (decay_idx < 6'(FACTOR_COUNT)) ? 17'(EXP_QUARTER_STEP[decay_idx]) : 17'd0;
			scaled = 34'(pk_level) * 34'(f) + 34'd32768;
			hold_cnt = '0;
			pk_level = scaled[31:16];
			// The decay count sticks at its top value instead of wrapping.
			if (decay_idx != DECAY_LAST)
				decay_idx = decay_idx + 6'd1;
		end
		r.peak = pk_level;
		if (pk_level >= cfg_threshold) begin
			r.act = sphd_pkg::ACT_TRANSCRIBE;
			armed = 1'b1;
		end else if (armed) begin
			// A flush leaves the hold and decay counts where they are.
			r.act    = sphd_pkg::ACT_FLUSH;
			armed    = 1'b0;
			pk_level = '0;
		end else begin
			r.act = sphd_pkg::ACT_NONE;
		end
		return r;
	endfunction

	// Offers one item and returns at the edge where it is taken. tvalid stays high
	// so that a following call keeps the stream going without a bubble.
	task automatic send_frame(input logic [15:0] prob);
		s_tvalid <= 1'b1;
		s_tdata  <= prob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_frames.push_back(advance_frame(prob));
		frames_sent++;
	endtask

	// Same as send_frame, but in bursts with random gaps when the sender idles.
	task automatic send_paced(input logic [15:0] prob);
		int gap;
		if (sender_idles && burst_left == 0) begin
			gap = $urandom_range(8, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(24, 1);
		end
		if (burst_left > 0)
			burst_left--;
		send_frame(prob);
	endtask

	// Stops offering and waits for every outstanding result, then lets the pipe settle.
	task automatic wait_for_results;
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only happen with the block idle, so the model updates at once.
	task automatic write_register(input logic [sphd_pkg::CFG_IDX_W-1:0] idx,
			input logic [sphd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == sphd_pkg::REG_HOLD_LIMIT)
			cfg_hold_limit = data[7:0];
		else if (idx == sphd_pkg::REG_TRIGGER_THRESHOLD)
			cfg_threshold = data;
		reg_writes++;
	endtask

	// Reset values: rises at and just under the threshold, holding at the full peak,
	// and the first decay step that leaves the peak unchanged.
	task automatic test_default_levels;
		rx_mode = RX_ALWAYS;
		sender_idles = 1'b0;
		send_frame(16'd0);
		send_frame(16'd45874);
		send_frame(16'd45875);
		send_frame(16'hFFFF);
		send_frame(16'hFFFF);
		repeat (6) send_frame(16'd0);
		wait_for_results;
	endtask

	// Lowering the hold limit under a running hold count forces the decay path on the
	// next frame; the top threshold makes the first real decay end in a flush.
	task automatic test_short_hold;
		write_register(sphd_pkg::REG_HOLD_LIMIT, 16'd0);
		write_register(sphd_pkg::REG_TRIGGER_THRESHOLD, 16'hFFFF);
		rx_mode = RX_PATTERN;
		send_frame(16'd0);
		send_frame(16'd0);
		send_frame(16'hFFFF);
		repeat (4) send_frame(16'd0);
		wait_for_results;
	endtask

	// With a zero threshold every frame transcribes. Writes to unused indexes carry
	// values that would show up at once if they reached either register.
	task automatic test_zero_threshold_and_stray_writes;
		write_register(sphd_pkg::REG_TRIGGER_THRESHOLD, 16'd0);
		write_register(REG_UNUSED_LOW, 16'hFFFF);
		write_register(REG_UNUSED_HIGH, 16'hFFFF);
		rx_mode = RX_ALWAYS;
		send_frame(16'd0);
		send_frame(16'hFFFF);
		send_frame(16'd0);
		send_frame(16'd0);
		wait_for_results;
	endtask

	// The receiver stops for a long stretch while items keep coming, so the pipeline
	// fills and the input stalls; afterwards the sender waits for every result.
	task automatic test_output_holdoff;
		write_register(sphd_pkg::REG_HOLD_LIMIT, 16'd2);
		write_register(sphd_pkg::REG_TRIGGER_THRESHOLD, 16'd30000);
		rx_mode = rx_mode_t'($urandom_range(3, 0));
		sender_idles = 1'b0;
		hold_off_request = HOLD_OFF_LEN;
		repeat (48) send_frame(16'($urandom));
		wait_for_results;
	endtask

	// Utterance-shaped traffic: a rise to a level, often near the threshold, then a
	// tail of silence, lower levels, repeats of the peak and some random noise.
	// Long tails walk the decay through its whole table and into saturation.
	task automatic test_random_utterances(input logic [7:0] hold_lim,
			input logic [15:0] thr, input int n_frames);
		int          sent;
		int          tail;
		int          lo;
		int          hi;
		logic [15:0] rise_v;
		logic [15:0] v;
		wait_for_results;
		write_register(sphd_pkg::REG_HOLD_LIMIT, {8'($urandom), hold_lim});
		write_register(sphd_pkg::REG_TRIGGER_THRESHOLD, thr);
		rx_mode = rx_mode_t'($urandom_range(3, 0));
		sender_idles = ($urandom_range(3, 0) != 0);
		burst_left = 0;
		sent = 0;
		while (sent < n_frames) begin
			case ($urandom_range(3, 0))
				0: rise_v = 16'($urandom);
				1: begin
					lo = (int'(thr) > 64) ? int'(thr) - 64 : 0;
					hi = (int'(thr) < 65471) ? int'(thr) + 64 : 65535;
					rise_v = 16'($urandom_range(hi, lo));
				end
				default: rise_v = 16'($urandom_range(65535, 16384));
			endcase
			send_paced(rise_v);
			sent++;
			tail = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60)
				: $urandom_range(30, 0);
			repeat (tail) begin
				case ($urandom_range(7, 0))
					0: v = 16'($urandom);
					1: v = rise_v;
					2, 3: v = 16'($urandom_range(int'(rise_v), 0));
					default: v = 16'd0;
				endcase
				send_paced(v);
				sent++;
			end
		end
		wait_for_results;
	endtask

	// Receiver: a pending hold-off wins, otherwise the current stall mode decides.
	always @(posedge clk) begin
		if (hold_off_request != 0) begin
			hold_left = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  m_tready <= 1'b1;
				RX_MOSTLY:  m_tready <= ($urandom_range(9, 0) < 7);
				RX_SPARSE:  m_tready <= ($urandom_range(9, 0) < 3);
				RX_PATTERN: begin
					m_tready   <= rx_pattern[0];
					rx_pattern <= {rx_pattern[0], rx_pattern[6:1]};
				end
				default:    m_tready <= 1'b1;
			endcase
		end
	end

	// Every result is compared against the oldest outstanding frame.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: result item with no frame outstanding, action %0d, peak %0d",
					$time, m_tdata[1:0], m_tdata[17:2]);
			end else begin
				want = expected_frames.pop_front();
				frames_checked++;
				if (want.act == sphd_pkg::ACT_TRANSCRIBE)
					transcribes_seen++;
				if (want.act == sphd_pkg::ACT_FLUSH)
					flushes_seen++;
				if (m_tdata[1:0] !== want.act) begin
					errors++;
					$display("%0t: action mismatch, expected %0d, got %0d",
						$time, want.act, m_tdata[1:0]);
				end
				if (m_tdata[17:2] !== want.peak) begin
					errors++;
					$display("%0t: reported peak mismatch, expected %0d, got %0d",
						$time, want.peak, m_tdata[17:2]);
				end
			end
		end
	end

	// Watchdog: ends the run if no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		pk_level       = '0;
		hold_cnt       = '0;
		decay_idx      = '0;
		armed          = 1'b0;
		cfg_hold_limit = sphd_pkg::HOLD_LIMIT_RESET;
		cfg_threshold  = sphd_pkg::TRIGGER_THRESHOLD_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_levels;
		test_short_hold;
		test_zero_threshold_and_stray_writes;

		test_random_utterances(8'd0, 16'd0, 250);
		test_random_utterances(8'd255, 16'hFFFF, 300);
		test_output_holdoff;
		test_random_utterances(sphd_pkg::HOLD_LIMIT_RESET,
			sphd_pkg::TRIGGER_THRESHOLD_RESET, 300);
		test_random_utterances(8'd1, 16'd20000, 300);
		test_random_utterances(8'($urandom), 16'($urandom), 300);
		test_random_utterances(8'd3, 16'($urandom), 300);

		wait_for_results;
		repeat (10) @(posedge clk);

		$display("Checked %0d of %0d frames: %0d transcribe and %0d flush results,",
			frames_checked, frames_sent, transcribes_seen, flushes_seen);
		$display("%0d register writes; hold limits and thresholds from zero to full scale,",
			reg_writes);
		$display("stray writes and a long output stall.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
